// ----- rtl/usb_audio_unpack_volume_assert.svh -----
// ----------------------------------------------------------------------------
// usb_audio_unpack_volume assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef USB_AUDIO_UNPACK_VOLUME_ASSERT_SVH
`define USB_AUDIO_UNPACK_VOLUME_ASSERT_SVH

`ifndef SYNTHESIS

`define UAVOL_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define UAVOL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define UAVOL_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define UAVOL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/uavol_pkg.sv -----
// ----------------------------------------------------------------------------
// uavol_pkg
// Shared constants, types and gain table of the USB audio unpack/volume block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package uavol_pkg;

  localparam int VOLUME_STEPS = 101;
  localparam int GAIN_IDX_W   = $clog2(VOLUME_STEPS);
  localparam int GAIN_W       = 30;
  localparam int GAIN_SHIFT   = 29;

  // configuration register indexes
  localparam logic [1:0] CFG_RESOLUTION   = 2'd0;
  localparam logic [1:0] CFG_LEFT_VOLUME  = 2'd1;
  localparam logic [1:0] CFG_RIGHT_VOLUME = 2'd2;

  // resolution codes
  localparam logic [1:0] RES_16   = 2'd0;
  localparam logic [1:0] RES_24   = 2'd1;
  localparam logic [1:0] RES_32   = 2'd2;
  localparam logic [1:0] RES_NONE = 2'd3;

  typedef logic [GAIN_W-1:0] gain_t;

  typedef struct packed {
    logic signed [31:0] left_raw;
    logic signed [31:0] right_raw;
    gain_t              left_gain;
    gain_t              right_gain;
    logic               last;
  } frame_t;

  localparam gain_t GAIN_TABLE [VOLUME_STEPS] = '{
    30'h20000000, 30'h1c8520af, 30'h196b230b, 30'h16a77dea, 30'h1430cd74,
    30'h11feb33c, 30'h1009b9cf, 30'h0e4b3b63, 30'h0cbd4b3f, 30'h0b5aa19b,
    30'h0a1e89b1, 30'h0904d1bd, 30'h0809bcc3, 30'h0729f5d9, 30'h066284d5,
    30'h05b0c438, 30'h05125831, 30'h04852697, 30'h04074fcb, 30'h03972853,
    30'h03333333, 30'h02da1cde, 30'h028ab6b4, 30'h0243f2fd, 30'h0204e158,
    30'h01ccab86, 30'h019a9294, 30'h016dec56, 30'h0146211f, 30'h0122a9c2,
    30'h01030dc4, 30'h00e6e1c6, 30'h00cdc613, 30'h00b76562, 30'h00a373ae,
    30'h0091ad38, 30'h0081d59e, 30'h0073b70f, 30'h00672194, 30'h005bea6e,
    30'h0051eb85, 30'h004902e3, 30'h00411245, 30'h0039feb2, 30'h0033b022,
    30'h002e1127, 30'h00290ea8, 30'h002497a2, 30'h00209ce9, 30'h001d10f9,
    30'h0019e7c6, 30'h00171693, 30'h001493ce, 30'h001256f0, 30'h0010585e,
    30'h000e9152, 30'h000cfbc3, 30'h000b924e, 30'h000a5028, 30'h0009310b,
    30'h00083126, 30'h00074d16, 30'h000681d3, 30'h0005ccab, 30'h00052b36,
    30'h00049b50, 30'h00041b10, 30'h0003a8c3, 30'h000342e4, 30'h0002e818,
    30'h0002972d, 30'h00024f0e, 30'h00020ec7, 30'h0001d57e, 30'h0001a26f,
    30'h000174ee, 30'h00014c60, 30'h0001283b, 30'h00010804, 30'h0000eb4d,
    30'h0000d1b7, 30'h0000bae8, 30'h0000a695, 30'h00009477, 30'h00008452,
    30'h000075ee, 30'h0000691b, 30'h00005dad, 30'h0000537d, 30'h00004a68,
    30'h00004251, 30'h00003b1b, 30'h000034ad, 30'h00002ef3, 30'h000029d7,
    30'h0000254b, 30'h0000213c, 30'h00001d9f, 30'h00001a66, 30'h00001787,
    30'h000014f8
  };

  // volume in 1/256 dB to gain: index = floor(-vol / 256), clamped
  function automatic gain_t gain_of(input logic signed [15:0] vol);
    logic signed [16:0]    neg;
    logic [7:0]            cand;
    logic [GAIN_IDX_W-1:0] idx;
    neg  = -{vol[15], vol};
    cand = neg[15:8];
    if (neg[16]) begin
      idx = '0;
    end else if ({1'b0, cand} > 9'(VOLUME_STEPS - 1)) begin
      idx = GAIN_IDX_W'(VOLUME_STEPS - 1);
    end else begin
      idx = cand[GAIN_IDX_W-1:0];
    end
    return GAIN_TABLE[idx];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/usb_audio_unpack_volume.sv -----
// ----------------------------------------------------------------------------
// usb_audio_unpack_volume
// USB audio byte stream to stereo PCM frames with per-channel digital volume.
// ----------------------------------------------------------------------------
// channel  ports                                       moves
// in       in_valid / in_stall, in_data_byte, in_last  one packet byte per request
// out      out_valid / out_stall, out_left/right, last one scaled stereo frame
// cfg      cfg_wr_en, cfg_index, cfg_data              register write, no wait
//
// one byte is accepted per clock while in_stall is low; a frame's last byte is
// registered into the frame register, then multiplied into the result register.
// both channel multipliers sit between the frame and result registers.
// reset is synchronous: resolution 16-bit, both volumes 0 dB, frame cleared.
// input stalls only while a finished frame waits behind a stalled result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module usb_audio_unpack_volume (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         in_data_byte,
  input  wire logic               in_last_byte,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_left_sample,
  output logic signed [31:0]      out_right_sample,
  output logic                    out_last_frame,
  input  wire logic               cfg_wr_en,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);

  import uavol_pkg::*;

  logic [1:0]         resolution_r;
  logic signed [15:0] left_volume_r;
  logic signed [15:0] right_volume_r;
  logic               frm_valid;
  logic               frm_ready;
  frame_t             frm;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resolution_r   <= RES_16;
      left_volume_r  <= '0;
      right_volume_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_RESOLUTION:   resolution_r   <= cfg_data[1:0];
        CFG_LEFT_VOLUME:  left_volume_r  <= cfg_data;
        CFG_RIGHT_VOLUME: right_volume_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  uavol_unpack u_unpack (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .resolution   (resolution_r),
    .left_volume  (left_volume_r),
    .right_volume (right_volume_r),
    .frm_valid    (frm_valid),
    .frm_ready    (frm_ready),
    .frm          (frm)
  );

  uavol_scale u_scale (
    .clk              (clk),
    .rst_n            (rst_n),
    .frm_valid        (frm_valid),
    .frm_ready        (frm_ready),
    .frm              (frm),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_left_sample  (out_left_sample),
    .out_right_sample (out_right_sample),
    .out_last_frame   (out_last_frame)
  );

endmodule

`default_nettype wire

// ----- rtl/uavol_unpack.sv -----
// ----------------------------------------------------------------------------
// uavol_unpack
// Byte assembler: builds left-aligned stereo frames and looks up the gains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "usb_audio_unpack_volume_assert.svh"

module uavol_unpack (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [7:0]           in_data_byte,
  input  wire logic                 in_last_byte,
  input  wire logic [1:0]           resolution,
  input  wire logic signed [15:0]   left_volume,
  input  wire logic signed [15:0]   right_volume,
  output logic                      frm_valid,
  input  wire logic                 frm_ready,
  output uavol_pkg::frame_t         frm
);

  import uavol_pkg::*;

  logic [2:0]         byte_pos_r, byte_pos_nxt;
  logic [23:0]        partial_r, partial_nxt;
  logic signed [31:0] held_left_r, held_left_nxt;
  logic               frm_valid_r, frm_valid_nxt;
  frame_t             frm_r, frm_nxt;

  logic               accept;
  logic               unsupported;
  logic [2:0]         bps;
  logic [3:0]         frame_len;
  logic [2:0]         pos;
  logic               second;
  logic [2:0]         k_full;
  logic [1:0]         k;
  logic               sample_done;
  logic               emit;
  logic [31:0]        w_join;
  logic [31:0]        w_aligned;

  assign in_stall  = frm_valid_r && !frm_ready;
  assign accept    = in_valid && !in_stall;
  assign frm_valid = frm_valid_r;
  assign frm       = frm_r;

  always_comb begin
    unsupported = (resolution == RES_NONE);
    bps         = {1'b0, resolution} + 3'd2;
    frame_len   = {bps, 1'b0};
    pos         = ({1'b0, byte_pos_r} >= frame_len) ? 3'd0 : byte_pos_r;
    second      = (pos >= bps);
    k_full      = second ? (pos - bps) : pos;
    k           = k_full[1:0];
    sample_done = !(({1'b0, k} + 3'd1) < bps);
    w_join      = {8'd0, partial_r} | ({24'd0, in_data_byte} << {k, 3'd0});
    case (resolution)
      RES_16:  w_aligned = w_join << 16;
      RES_24:  w_aligned = w_join << 8;
      default: w_aligned = w_join;
    endcase
    emit = accept && !unsupported && sample_done && second;
  end

  always_comb begin
    byte_pos_nxt  = byte_pos_r;
    partial_nxt   = partial_r;
    held_left_nxt = held_left_r;
    if (accept) begin
      if (unsupported) begin
        byte_pos_nxt = 3'd0;
        partial_nxt  = '0;
      end else if (!sample_done) begin
        if (k == 2'd0) begin
          partial_nxt = {16'd0, in_data_byte};
        end else begin
          partial_nxt = partial_r | ({16'd0, in_data_byte} << {k, 3'd0});
        end
        byte_pos_nxt = pos + 3'd1;
      end else begin
        partial_nxt = '0;
        if (!second) begin
          held_left_nxt = w_aligned;
          byte_pos_nxt  = pos + 3'd1;
        end else begin
          byte_pos_nxt = 3'd0;
        end
      end
      if (in_last_byte) begin
        byte_pos_nxt = 3'd0;
        partial_nxt  = '0;
      end
    end
  end

  always_comb begin
    frm_nxt       = frm_r;
    frm_valid_nxt = frm_valid_r;
    if (emit) begin
      frm_valid_nxt      = 1'b1;
      frm_nxt.left_raw   = held_left_r;
      frm_nxt.right_raw  = w_aligned;
      frm_nxt.left_gain  = gain_of(left_volume);
      frm_nxt.right_gain = gain_of(right_volume);
      frm_nxt.last       = in_last_byte;
    end else if (frm_ready) begin
      frm_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r  <= '0;
      partial_r   <= '0;
      held_left_r <= '0;
      frm_valid_r <= 1'b0;
    end else begin
      byte_pos_r  <= byte_pos_nxt;
      partial_r   <= partial_nxt;
      held_left_r <= held_left_nxt;
      frm_valid_r <= frm_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frm_r <= frm_nxt;
  end

  `UAVOL_ASSERT_NEXT(a_frm_hold, clk, rst_n, frm_valid_r && !frm_ready, frm_valid_r && $stable(frm_r))
  `UAVOL_ASSERT_NEXT(a_last_clears, clk, rst_n, accept && in_last_byte, byte_pos_r == 3'd0 && partial_r == 24'd0)
  `UAVOL_ASSERT_NEXT(a_unsup_clears, clk, rst_n, accept && unsupported, byte_pos_r == 3'd0 && partial_r == 24'd0)

endmodule

`default_nettype wire

// ----- rtl/uavol_scale.sv -----
// ----------------------------------------------------------------------------
// uavol_scale
// Gain multiply of both channels and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module uavol_scale (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               frm_valid,
  output logic                    frm_ready,
  input  wire uavol_pkg::frame_t  frm,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_left_sample,
  output logic signed [31:0]      out_right_sample,
  output logic                    out_last_frame
);

  import uavol_pkg::*;

  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] left_r, right_r;
  logic               last_r;
  logic signed [62:0] prod_l;
  logic signed [62:0] prod_r;
  logic               load;

  assign frm_ready = !out_valid_r || !out_stall;
  assign load      = frm_valid && frm_ready;

  // signed sample times unsigned gain, floor shift then keep 32 bits
  assign prod_l = 63'(frm.left_raw) * 63'($signed({1'b0, frm.left_gain}));
  assign prod_r = 63'(frm.right_raw) * 63'($signed({1'b0, frm.right_gain}));

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      left_r  <= prod_l[GAIN_SHIFT+31:GAIN_SHIFT];
      right_r <= prod_r[GAIN_SHIFT+31:GAIN_SHIFT];
      last_r  <= frm.last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_left_sample  = left_r;
  assign out_right_sample = right_r;
  assign out_last_frame   = last_r;

endmodule

`default_nettype wire

// ----- tb/usb_audio_unpack_volume_checker.sv -----
// ----------------------------------------------------------------------------
// usb_audio_unpack_volume_checker
// Watches the byte, frame and register ports of the unpack/volume block. Each
// accepted byte goes through an independent model of the frame assembly and
// gain stage, and every accepted frame is compared field by field with the
// oldest predicted frame. Mismatches and unexpected frames are counted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module usb_audio_unpack_volume_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [7:0]         in_data_byte,
  input  logic               in_last_byte,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] out_left_sample,
  input  logic signed [31:0] out_right_sample,
  input  logic               out_last_frame,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 frames_pending,
  output int                 fail_count
);

  import uavol_pkg::*;

  typedef struct packed {
    logic [31:0] left;
    logic [31:0] right;
    logic        last;
  } stereo_frame_t;

  // gain per 1 dB step, 0 dB down to -100 dB, unity = 2^29
  localparam logic [31:0] GAIN_BY_DB [VOLUME_STEPS] = '{
    32'h20000000, 32'h1c8520af, 32'h196b230b, 32'h16a77dea, 32'h1430cd74,
    32'h11feb33c, 32'h1009b9cf, 32'h0e4b3b63, 32'h0cbd4b3f, 32'h0b5aa19b,
    32'h0a1e89b1, 32'h0904d1bd, 32'h0809bcc3, 32'h0729f5d9, 32'h066284d5,
    32'h05b0c438, 32'h05125831, 32'h04852697, 32'h04074fcb, 32'h03972853,
    32'h03333333, 32'h02da1cde, 32'h028ab6b4, 32'h0243f2fd, 32'h0204e158,
    32'h01ccab86, 32'h019a9294, 32'h016dec56, 32'h0146211f, 32'h0122a9c2,
    32'h01030dc4, 32'h00e6e1c6, 32'h00cdc613, 32'h00b76562, 32'h00a373ae,
    32'h0091ad38, 32'h0081d59e, 32'h0073b70f, 32'h00672194, 32'h005bea6e,
    32'h0051eb85, 32'h004902e3, 32'h00411245, 32'h0039feb2, 32'h0033b022,
    32'h002e1127, 32'h00290ea8, 32'h002497a2, 32'h00209ce9, 32'h001d10f9,
    32'h0019e7c6, 32'h00171693, 32'h001493ce, 32'h001256f0, 32'h0010585e,
    32'h000e9152, 32'h000cfbc3, 32'h000b924e, 32'h000a5028, 32'h0009310b,
    32'h00083126, 32'h00074d16, 32'h000681d3, 32'h0005ccab, 32'h00052b36,
    32'h00049b50, 32'h00041b10, 32'h0003a8c3, 32'h000342e4, 32'h0002e818,
    32'h0002972d, 32'h00024f0e, 32'h00020ec7, 32'h0001d57e, 32'h0001a26f,
    32'h000174ee, 32'h00014c60, 32'h0001283b, 32'h00010804, 32'h0000eb4d,
    32'h0000d1b7, 32'h0000bae8, 32'h0000a695, 32'h00009477, 32'h00008452,
    32'h000075ee, 32'h0000691b, 32'h00005dad, 32'h0000537d, 32'h00004a68,
    32'h00004251, 32'h00003b1b, 32'h000034ad, 32'h00002ef3, 32'h000029d7,
    32'h0000254b, 32'h0000213c, 32'h00001d9f, 32'h00001a66, 32'h00001787,
    32'h000014f8
  };

  logic [1:0]         resolution;
  logic signed [15:0] left_volume;
  logic signed [15:0] right_volume;
  logic [2:0]         frame_pos;
  logic [23:0]        gathered;
  logic [31:0]        held_left;
  stereo_frame_t      expected_frames[$];
  int                 mismatches = 0;

  assign fail_count = mismatches;

  function automatic logic [31:0] gain_for_volume(input logic signed [15:0] volume);
    int atten;
    int step;
    atten = -int'(volume);
    step  = (atten >= 0) ? atten / 256 : 0;
    if (step > VOLUME_STEPS - 1) step = VOLUME_STEPS - 1;
    return GAIN_BY_DB[step];
  endfunction

  // floor shift by 29, keep the low 32 bits
  function automatic logic [31:0] apply_gain(input logic [31:0] sample,
                                             input logic [31:0] gain);
    logic signed [63:0] product;
    product = $signed({{32{sample[31]}}, sample}) * $signed({32'd0, gain});
    return product[60:29];
  endfunction

  task automatic unpack_byte(input logic [7:0] data, input logic last);
    int            bps;
    int            pos;
    int            k;
    logic [31:0]   word;
    stereo_frame_t frame;
    if (resolution == RES_NONE) begin
      frame_pos = '0;
      gathered  = '0;
      return;
    end
    case (resolution)
      RES_24:  bps = 3;
      RES_32:  bps = 4;
      default: bps = 2;
    endcase
    pos = frame_pos;
    if (pos >= 2 * bps) pos = 0;
    k = (pos < bps) ? pos : pos - bps;
    if (k + 1 < bps) begin
      if (k == 0) gathered = {16'd0, data};
      else gathered = gathered | (24'(data) << (8 * k));
      frame_pos = 3'(pos + 1);
    end else begin
      word     = {8'd0, gathered} | (32'(data) << (8 * k));
      word     = word << (8 * (4 - bps));
      gathered = '0;
      if (pos < bps) begin
        held_left = word;
        frame_pos = 3'(pos + 1);
      end else begin
        frame.left  = apply_gain(held_left, gain_for_volume(left_volume));
        frame.right = apply_gain(word, gain_for_volume(right_volume));
        frame.last  = last;
        expected_frames.push_back(frame);
        frame_pos = '0;
      end
    end
    if (last) begin
      frame_pos = '0;
      gathered  = '0;
    end
  endtask

  always @(posedge clk) begin : watch
    stereo_frame_t want;
    if (!rst_n) begin
      resolution   = RES_16;
      left_volume  = '0;
      right_volume = '0;
      frame_pos    = '0;
      gathered     = '0;
      held_left    = '0;
      expected_frames.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_frames.size() == 0) begin
          $error("unexpected frame: left %h right %h last %b",
                 out_left_sample, out_right_sample, out_last_frame);
          mismatches++;
        end else begin
          want = expected_frames.pop_front();
          if (out_left_sample !== want.left) begin
            $error("left_sample: expected %h, got %h", want.left, out_left_sample);
            mismatches++;
          end
          if (out_right_sample !== want.right) begin
            $error("right_sample: expected %h, got %h", want.right, out_right_sample);
            mismatches++;
          end
          if (out_last_frame !== want.last) begin
            $error("last_frame: expected %b, got %b", want.last, out_last_frame);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) unpack_byte(in_data_byte, in_last_byte);
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_RESOLUTION:   resolution   = cfg_data[1:0];
          CFG_LEFT_VOLUME:  left_volume  = cfg_data;
          CFG_RIGHT_VOLUME: right_volume = cfg_data;
          default: ;
        endcase
      end
    end
    frames_pending <= expected_frames.size();
  end

endmodule

// ----- tb/usb_audio_unpack_volume_tb.sv -----
// ----------------------------------------------------------------------------
// usb_audio_unpack_volume_tb
// Drives packet bytes and register writes into the unpack/volume block: a
// short directed sequence for full-scale samples, dropped partial frames,
// unsupported and changed resolutions and volume extremes, then random
// packets under random volume and resolution settings with random gaps on
// both sides. The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module usb_audio_unpack_volume_tb;

  import uavol_pkg::*;

  localparam int RANDOM_BYTES   = 850;
  localparam int WATCHDOG_LIMIT = 2000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_data_byte = '0;
  logic               in_last_byte = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_left_sample;
  logic signed [31:0] out_right_sample;
  logic               out_last_frame;
  logic               cfg_wr_en = 1'b0;
  logic [1:0]         cfg_index = CFG_RESOLUTION;
  logic [15:0]        cfg_data = '0;
  int                 frames_pending;
  int                 fail_count;
  int                 idle_pct = 18;
  int                 quiet_cycles = 0;

  usb_audio_unpack_volume i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_left_sample  (out_left_sample),
    .out_right_sample (out_right_sample),
    .out_last_frame   (out_last_frame),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  usb_audio_unpack_volume_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_left_sample  (out_left_sample),
    .out_right_sample (out_right_sample),
    .out_last_frame   (out_last_frame),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .frames_pending   (frames_pending),
    .fail_count       (fail_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $error("no request accepted for %0d cycles", quiet_cycles);
        $display("** usb_audio_unpack_volume: FAILED **");
        $finish;
      end
    end
  end

  function automatic logic [7:0] random_byte();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hff;
      2:       return 8'h80;
      3:       return 8'h7f;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [15:0] random_volume();
    case ($urandom_range(5))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'(-(($urandom_range(100) * 256) + $urandom_range(255)));
      4:       return 16'(-($urandom_range(101) * 256));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [1:0] random_resolution();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return RES_NONE;
    else if (pick < 4) return RES_16;
    else if (pick < 7) return RES_24;
    else return RES_32;
  endfunction

  task automatic push_byte(input logic [7:0] data, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= data;
    in_last_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // hold off the sender until every predicted frame is out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (frames_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_config(input logic [1:0] res, input logic [15:0] left_vol,
                              input logic [15:0] right_vol);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_RESOLUTION;
    cfg_data  <= 16'(res);
    @(posedge clk);
    cfg_index <= CFG_LEFT_VOLUME;
    cfg_data  <= left_vol;
    @(posedge clk);
    cfg_index <= CFG_RIGHT_VOLUME;
    cfg_data  <= right_vol;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // whole frames, sometimes a trailing partial frame, sometimes no end marker
  task automatic send_random_packet(input int frame_bytes, output int sent);
    int  frames;
    int  extra;
    bit  mark_end;
    frames   = $urandom_range(6);
    extra    = ($urandom_range(4) == 0) ? $urandom_range(frame_bytes - 1, 1) : 0;
    mark_end = ($urandom_range(9) != 0);
    sent     = frames * frame_bytes + extra;
    if (sent == 0) sent = 1;
    for (int i = 0; i < sent; i++) begin
      push_byte(random_byte(), mark_end && (i == sent - 1));
    end
  endtask

  initial begin : stimulus
    int         total;
    int         phase;
    int         packets;
    int         count;
    int         frame_bytes;
    logic [1:0] res;
    total = 0;
    phase = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: 16-bit, 0 dB, full-scale samples
    push_byte(8'h00, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'h7f, 1'b1);
    // unfinished frame at packet end
    push_byte(8'h00, 1'b0);
    push_byte(8'hff, 1'b1);
    drain();
    write_config(RES_24, 16'h8000, 16'h7fff);
    push_byte(8'hff, 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'h7f, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h80, 1'b1);
    push_byte(8'h01, 1'b0);
    push_byte(8'h02, 1'b0);
    push_byte(8'h03, 1'b0);
    push_byte(8'h04, 1'b0);
    drain();
    // frame position now past the 16-bit frame size
    write_config(RES_16, 16'hff00, 16'h0000);
    push_byte(8'h11, 1'b0);
    push_byte(8'h22, 1'b0);
    push_byte(8'h33, 1'b0);
    push_byte(8'h44, 1'b1);
    drain();
    write_config(RES_NONE, 16'h0000, 16'h0000);
    push_byte(8'h5a, 1'b1);
    drain();
    write_config(RES_32, 16'hd800, 16'hff01);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'h7f, 1'b1);

    while (total < RANDOM_BYTES) begin
      idle_pct = (phase >= 10 && phase < 16) ? 0 : 18;
      drain();
      res = random_resolution();
      write_config(res, random_volume(), random_volume());
      case (res)
        RES_24:  frame_bytes = 6;
        RES_32:  frame_bytes = 8;
        default: frame_bytes = 4;
      endcase
      packets = $urandom_range(4, 1);
      repeat (packets) begin
        send_random_packet(frame_bytes, count);
        total += count;
      end
      phase++;
    end

    idle_pct = 18;
    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && frames_pending == 0) begin
      $display("** usb_audio_unpack_volume: PASSED **");
    end else begin
      $display("** usb_audio_unpack_volume: FAILED **");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/uavol_pkg.sv
rtl/uavol_unpack.sv
rtl/uavol_scale.sv
rtl/usb_audio_unpack_volume.sv
tb/usb_audio_unpack_volume_checker.sv
tb/usb_audio_unpack_volume_tb.sv
